// File: hdl/pixel_command_frame_writer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel command frame writer
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_COMMAND_FRAME_WRITER_ASSERT_SVH
`define PIXEL_COMMAND_FRAME_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset
`define PCFW_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("pcfw assertion failed");
// Check that cons holds whenever ante holds, outside reset
`define PCFW_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pcfw assertion failed");
`else
`define PCFW_ASSERT(name, clk, rstn, prop)
`define PCFW_ASSERT_IMP(name, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/pcfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfw_pkg
// Shared types, command codes and color packing for the frame writer.
// ----------------------------------------------------------------------------
package pcfw_pkg;

    // Command codes
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_PIXELS = 8'h02;
    localparam logic [7:0] CMD_APPLY  = 8'h03;

    // RGB565 channel masks
    localparam logic [7:0] RED_MASK   = 8'hF8;
    localparam logic [7:0] GREEN_MASK = 8'hFC;

    // Position of the next byte within a packet
    typedef enum logic [2:0] {
        PH_CMD   = 3'd0,
        PH_RED   = 3'd1,
        PH_GREEN = 3'd2,
        PH_BLUE  = 3'd3,
        PH_X     = 3'd4,
        PH_Y     = 3'd5,
        PH_SKIP  = 3'd6
    } phase_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_INIT  = 2'd0,
        ST_RUN   = 2'd1,
        ST_CLEAR = 2'd2
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic load_item;
        logic load_clear;
        logic sweep_en;
    } dp_ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic start_clear;
        logic sweep_last;
    } dp_sts_t;

    // Pack red, green, blue bytes into RGB565
    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [15:0] v;
        v = {r & RED_MASK, 8'h00} | {5'b0, g & GREEN_MASK, 3'b0} | {11'b0, b[7:3]};
        return v;
    endfunction

endpackage

// File: hdl/pixel_command_frame_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_command_frame_writer
// Parses byte-wide command packets and writes RGB565 pixels into a frame store.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  command   cmd_valid / cmd_stall  data_byte, last_byte
//  result    res_valid / res_stall  pixel_write, pixel_x, pixel_y, pixel_color,
//                                   frame_cleared, frame_apply
//
//  Each request gives one result; ordinary bytes are taken one per cycle while
//  the result slot is free. A clear command holds cmd_stall while the single
//  store write port zeroes one entry per cycle, then gives its result.
//  After reset the same sweep runs, with cmd_stall held.
//  A held result register stalls the command side only when it is still full.
// ----------------------------------------------------------------------------
module pixel_command_frame_writer
    import pcfw_pkg::*;
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        pixel_write,
    output logic [5:0]  pixel_x,
    output logic [5:0]  pixel_y,
    output logic [15:0] pixel_color,
    output logic        frame_cleared,
    output logic        frame_apply
);

    dp_ctl_t ctl;
    dp_sts_t sts;

    // Controller
    pcfw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Datapath
    pcfw_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .pixel_write   (pixel_write),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_color   (pixel_color),
        .frame_cleared (frame_cleared),
        .frame_apply   (frame_apply)
    );

endmodule

// File: hdl/pcfw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfw_ctrl
// Handshake and sequencing: reset sweep, byte acceptance, clear sweep.
// ----------------------------------------------------------------------------
`include "pixel_command_frame_writer_assert.svh"

module pcfw_ctrl
    import pcfw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_stall,
    output logic    res_valid,
    input  logic    res_stall,
    input  dp_sts_t sts,
    output dp_ctl_t ctl
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || !res_stall;
    assign res_valid = out_valid_reg;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && res_stall;
        cmd_stall      = 1'b1;
        ctl            = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.sweep_en = 1'b1;
                if (sts.sweep_last)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd_stall = !slot_free;
                if (cmd_valid && slot_free)
                begin
                    ctl.accept = 1'b1;
                    if (sts.start_clear)
                        state_next = ST_CLEAR;
                    else
                    begin
                        ctl.load_item  = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                ctl.sweep_en = 1'b1;
                if (sts.sweep_last)
                begin
                    ctl.load_clear = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Sweeps block new requests; a clear result appears only at sweep end
    `PCFW_ASSERT_IMP(a_sweep_stalls, clk, rst_n, state_reg != ST_RUN, cmd_stall)
    `PCFW_ASSERT_IMP(a_clear_empty, clk, rst_n, state_reg == ST_CLEAR, !out_valid_reg)
    `PCFW_ASSERT_IMP(a_clear_done, clk, rst_n, ctl.load_clear,
                     state_reg == ST_CLEAR && sts.sweep_last)
    `PCFW_ASSERT_IMP(a_clear_entry, clk, rst_n, ctl.accept && sts.start_clear,
                     ##1 state_reg == ST_CLEAR)

endmodule

// File: hdl/pcfw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfw_datapath
// Packet parsing registers, pixel store with sweep counter, result registers.
// ----------------------------------------------------------------------------
module pcfw_datapath
    import pcfw_pkg::*;
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_ctl_t     ctl,
    output dp_sts_t     sts,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        pixel_write,
    output logic [5:0]  pixel_x,
    output logic [5:0]  pixel_y,
    output logic [15:0] pixel_color,
    output logic        frame_cleared,
    output logic        frame_apply
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Parse state
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  red_reg;
    logic [7:0]  red_next;
    logic [7:0]  green_reg;
    logic [7:0]  green_next;
    logic [15:0] color_reg;
    logic [15:0] color_next;
    logic [7:0]  column_reg;
    logic [7:0]  column_next;

    // Store and sweep
    logic [15:0]   store_mem [DEPTH];
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata;
    logic [16:0]   lin_addr;

    // Per-byte results
    logic          in_range;
    logic          hit_write;
    logic          hit_apply;

    // Result registers
    logic          wr_reg;
    logic [5:0]    x_reg;
    logic [5:0]    y_reg;
    logic [15:0]   c_reg;
    logic          clr_reg;
    logic          app_reg;

    assign in_range = ({1'b0, column_reg} < 9'(FRAME_WIDTH))
                   && ({1'b0, data_byte} < 9'(FRAME_HEIGHT));
    assign lin_addr = 17'(data_byte) * 17'(FRAME_WIDTH) + 17'(column_reg);

    assign sts.start_clear = (phase_reg == PH_CMD) && (data_byte == CMD_CLEAR);
    assign sts.sweep_last  = (sweep_reg == AW'(DEPTH - 1));

    // Decode the byte against the packet phase
    always_comb
    begin
        phase_next  = phase_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        color_next  = color_reg;
        column_next = column_reg;
        hit_write   = 1'b0;
        hit_apply   = 1'b0;
        unique case (phase_reg)
            PH_CMD:
            begin
                unique case (data_byte)
                    CMD_PIXELS: phase_next = PH_RED;
                    CMD_APPLY:
                    begin
                        hit_apply  = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    default:    phase_next = PH_SKIP;
                endcase
            end
            PH_RED:
            begin
                red_next   = data_byte;
                phase_next = PH_GREEN;
            end
            PH_GREEN:
            begin
                green_next = data_byte;
                phase_next = PH_BLUE;
            end
            PH_BLUE:
            begin
                color_next = pack565(red_reg, green_reg, data_byte);
                phase_next = PH_X;
            end
            PH_X:
            begin
                column_next = data_byte;
                phase_next  = PH_Y;
            end
            PH_Y:
            begin
                hit_write  = in_range;
                phase_next = PH_X;
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase
        if (last_byte)
            phase_next = PH_CMD;
    end

    // Advance the sweep address, wrapping after the last entry
    always_comb
    begin
        sweep_next = sweep_reg;
        if (ctl.sweep_en)
            sweep_next = sts.sweep_last ? '0 : sweep_reg + AW'(1);
    end

    // Share the store write port between sweep and pixel writes
    always_comb
    begin
        if (ctl.sweep_en)
        begin
            mem_we    = 1'b1;
            mem_addr  = sweep_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = ctl.accept && hit_write;
            mem_addr  = lin_addr[AW-1:0];
            mem_wdata = color_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CMD;
            red_reg    <= '0;
            green_reg  <= '0;
            color_reg  <= '0;
            column_reg <= '0;
            sweep_reg  <= '0;
        end
        else
        begin
            sweep_reg <= sweep_next;
            if (ctl.accept)
            begin
                phase_reg  <= phase_next;
                red_reg    <= red_next;
                green_reg  <= green_next;
                color_reg  <= color_next;
                column_reg <= column_next;
            end
        end
    end

    // Pixel store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= mem_wdata;
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            wr_reg  <= hit_write;
            x_reg   <= hit_write ? column_reg[5:0] : 6'd0;
            y_reg   <= hit_write ? data_byte[5:0] : 6'd0;
            c_reg   <= hit_write ? color_reg : 16'd0;
            clr_reg <= 1'b0;
            app_reg <= hit_apply;
        end
        else if (ctl.load_clear)
        begin
            wr_reg  <= 1'b0;
            x_reg   <= '0;
            y_reg   <= '0;
            c_reg   <= '0;
            clr_reg <= 1'b1;
            app_reg <= 1'b0;
        end
    end

    assign pixel_write   = wr_reg;
    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign pixel_color   = c_reg;
    assign frame_cleared = clr_reg;
    assign frame_apply   = app_reg;

endmodule
